FILE: rtl/core/assert_macros.svh
// Assertion macros included by the list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, ignored while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication: when the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ile_pkg.sv
`default_nettype none

package ile_pkg;

    // Default number of list entries.
    localparam int unsigned CAPACITY_DEF = 16;

    // Field widths fixed by the interface.
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned INDEX_W  = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    // Operation codes carried by func.
    typedef enum logic [FUNC_W-1:0] {
        FN_READ   = 3'd0,
        FN_PUSH   = 3'd1,
        FN_POP    = 3'd2,
        FN_INSERT = 3'd3,
        FN_REMOVE = 3'd4,
        FN_SWAP   = 3'd5
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_WAIT,
        S_INS,
        S_INS_PUT,
        S_REM,
        S_SW_RB,
        S_SW_WA,
        S_SW_WB,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/ile_ram.sv
`default_nettype none

module ile_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/indexed_list_engine.sv
// Channel   Handshake              Fields
// req       req_valid / req_ready  func, value, index_a, index_b
// rsp       rsp_valid / rsp_ready  read_value, status, count
//
// One item at a time; req_ready is high only while the sequencer is idle.
// Push, pop, failed requests and unused codes go from execute straight to done;
// read waits for the memory; swap reads both entries and writes them exchanged.
// Insert and remove move the tail of the list one entry per cycle.
// A result waits in the output register; the next one stalls until it is taken.
// Reset clears the list length and the handshake state; the list memory is not cleared.
`default_nettype none

module indexed_list_engine #(
    parameter int unsigned CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [ile_pkg::FUNC_W-1:0]    func,
    input  wire logic signed [ile_pkg::DATA_W-1:0] value,
    input  wire logic [ile_pkg::INDEX_W-1:0]   index_a,
    input  wire logic [ile_pkg::INDEX_W-1:0]   index_b,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output logic signed [ile_pkg::DATA_W-1:0]  read_value,
    output logic [ile_pkg::STATUS_W-1:0]       status,
    output logic [ile_pkg::COUNT_W-1:0]        count
);

    import ile_pkg::*;

    `include "assert_macros.svh"

    // Address, length and compare widths.
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned LW = $clog2(CAPACITY + 1);
    localparam int unsigned CW = (LW > INDEX_W) ? LW : INDEX_W;

    state_t               state_reg, state_next;
    logic [LW-1:0]        len_reg, len_next;
    logic                 pend_reg, pend_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    func_t                func_reg, func_next;
    logic [DATA_W-1:0]    value_reg, value_next;
    logic [CW-1:0]        ia_reg, ia_next;
    logic [CW-1:0]        ib_reg, ib_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [DATA_W-1:0]    tmp_reg, tmp_next;
    logic [DATA_W-1:0]    rv_reg, rv_next;
    status_t              st_reg, st_next;
    logic [DATA_W-1:0]    read_value_reg, read_value_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_wr_addr;
    logic [DATA_W-1:0]    ram_wr_data;
    logic [AW-1:0]        ram_rd_addr;
    logic [DATA_W-1:0]    ram_rd_data;

    logic [CW-1:0]        len_ext;
    logic [CW-1:0]        len_next_ext;
    logic                 ia_ge_len;
    logic                 ia_gt_len;
    logic                 ib_ge_len;
    logic                 is_full;
    logic                 is_empty;
    logic                 ins_more;
    logic                 rem_more;
    logic                 out_free;
    logic                 wr_state;
    logic                 done_full;

    // List storage.
    ile_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Shared range checks against the current length, shift-loop tests and output-free flag.
    assign len_ext      = CW'(len_reg);
    assign len_next_ext = CW'(len_next);
    assign ia_ge_len    = (ia_reg >= len_ext);
    assign ia_gt_len    = (ia_reg > len_ext);
    assign ib_ge_len    = (ib_reg >= len_ext);
    assign is_full      = (len_ext >= CW'(CAPACITY));
    assign is_empty     = (len_reg == '0);
    assign ins_more     = (ptr_reg > ia_reg);
    assign rem_more     = ((ptr_reg + CW'(1)) < len_ext);
    assign out_free     = !rsp_valid_reg || rsp_ready;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (func_reg)
                    FN_READ:   state_next = ia_ge_len ? S_DONE : S_RD_WAIT;
                    FN_INSERT: state_next = (ia_gt_len || is_full) ? S_DONE : S_INS;
                    FN_REMOVE: state_next = ia_ge_len ? S_DONE : S_REM;
                    FN_SWAP:   state_next = (ia_ge_len || ib_ge_len) ? S_DONE : S_SW_RB;
                    default:   state_next = S_DONE;
                endcase
            end
            S_RD_WAIT: state_next = S_DONE;
            S_INS:
            begin
                if (!ins_more)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT: state_next = S_DONE;
            S_REM:
            begin
                if (!rem_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_SW_RB: state_next = S_SW_WA;
            S_SW_WA: state_next = S_SW_WB;
            S_SW_WB: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory control and datapath next values.
    always_comb
    begin
        len_next        = len_reg;
        pend_next       = pend_reg;
        func_next       = func_reg;
        value_next      = value_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        ptr_next        = ptr_reg;
        pend_addr_next  = pend_addr_reg;
        tmp_next        = tmp_reg;
        rv_next         = rv_reg;
        st_next         = st_reg;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = pend_addr_reg;
        ram_wr_data     = ram_rd_data;
        ram_rd_addr     = ia_reg[AW-1:0];

        // A taken result frees the output register.
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            S_IDLE:
            begin
                func_next  = func_t'(func);
                value_next = value;
                ia_next    = CW'(index_a);
                ib_next    = CW'(index_b);
            end
            S_EXEC:
            begin
                rv_next   = '0;
                st_next   = STAT_DONE;
                pend_next = 1'b0;
                case (func_reg)
                    FN_READ:
                    begin
                        if (ia_ge_len)
                        begin
                            st_next = STAT_RANGE;
                        end
                    end
                    FN_PUSH:
                    begin
                        if (is_full)
                        begin
                            st_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_wr_addr = len_ext[AW-1:0];
                            ram_wr_data = value_reg;
                            len_next    = len_reg + LW'(1);
                        end
                    end
                    FN_POP:
                    begin
                        if (is_empty)
                        begin
                            st_next = STAT_RANGE;
                        end
                        else
                        begin
                            len_next = len_reg - LW'(1);
                        end
                    end
                    FN_INSERT:
                    begin
                        if (ia_gt_len)
                        begin
                            st_next = STAT_RANGE;
                        end
                        else if (is_full)
                        begin
                            st_next = STAT_FULL;
                        end
                        ptr_next = len_ext;
                    end
                    FN_REMOVE:
                    begin
                        if (ia_ge_len)
                        begin
                            st_next = STAT_RANGE;
                        end
                        ptr_next = ia_reg;
                    end
                    FN_SWAP:
                    begin
                        if (ia_ge_len || ib_ge_len)
                        begin
                            st_next = STAT_RANGE;
                        end
                    end
                    default:
                    begin
                        st_next = STAT_DONE;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                rv_next = ram_rd_data;
            end
            S_INS:
            begin
                // Write back the entry read last cycle one place further on.
                ram_we = pend_reg;
                if (ins_more)
                begin
                    ram_rd_addr    = ptr_reg[AW-1:0] - AW'(1);
                    pend_addr_next = ptr_reg[AW-1:0];
                    pend_next      = 1'b1;
                    ptr_next       = ptr_reg - CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_INS_PUT:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = ia_reg[AW-1:0];
                ram_wr_data = value_reg;
                len_next    = len_reg + LW'(1);
            end
            S_REM:
            begin
                // Write back the entry read last cycle one place nearer the front.
                ram_we = pend_reg;
                if (rem_more)
                begin
                    ram_rd_addr    = ptr_reg[AW-1:0] + AW'(1);
                    pend_addr_next = ptr_reg[AW-1:0];
                    pend_next      = 1'b1;
                    ptr_next       = ptr_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    len_next  = len_reg - LW'(1);
                end
            end
            S_SW_RB:
            begin
                ram_rd_addr = ib_reg[AW-1:0];
                tmp_next    = ram_rd_data;
            end
            S_SW_WA:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = ia_reg[AW-1:0];
                ram_wr_data = ram_rd_data;
            end
            S_SW_WB:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = ib_reg[AW-1:0];
                ram_wr_data = tmp_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    read_value_next = rv_reg;
                    status_next     = st_reg;
                    count_next      = len_next_ext[COUNT_W-1:0];
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        value_reg      <= value_next;
        ia_reg         <= ia_next;
        ib_reg         <= ib_next;
        ptr_reg        <= ptr_next;
        pend_addr_reg  <= pend_addr_next;
        tmp_reg        <= tmp_next;
        rv_reg         <= rv_next;
        st_reg         <= st_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
        count_reg      <= count_next;
    end

    // Port drive.
    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = count_reg;

    // States in which the memory may be written, and a full result at completion.
    assign wr_state  = (state_reg == S_EXEC) || (state_reg == S_INS) ||
                       (state_reg == S_INS_PUT) || (state_reg == S_REM) ||
                       (state_reg == S_SW_WA) || (state_reg == S_SW_WB);
    assign done_full = (state_reg == S_DONE) && (st_reg == STAT_FULL);

    // Checks on the sequencer and the length.
    `ASSERT_CLK(a_len_bound, len_ext <= CW'(CAPACITY), "list length exceeds capacity")
    `ASSERT_IMPLY(a_we_states, ram_we, wr_state, "memory written outside a write state")
    `ASSERT_IMPLY(a_full_len, done_full, is_full, "full status with room left")
    `ASSERT_IMPLY(a_no_pend, state_reg == S_DONE, !pend_reg, "shift write left pending at completion")
    `ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_reg == S_EXEC, "accepted item not executed")

endmodule

`default_nettype wire

FILE: dv/ile_list_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the list engine, keeps its own copy of the list,
// works out the result of every accepted request and compares each returned item
// with the oldest outstanding prediction.
module ile_list_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    input  logic                                  req_ready,
    input  logic [ile_pkg::FUNC_W-1:0]            func,
    input  logic signed [ile_pkg::DATA_W-1:0]     value,
    input  logic [ile_pkg::INDEX_W-1:0]           index_a,
    input  logic [ile_pkg::INDEX_W-1:0]           index_b,
    input  logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    input  logic signed [ile_pkg::DATA_W-1:0]     read_value,
    input  logic [ile_pkg::STATUS_W-1:0]          status,
    input  logic [ile_pkg::COUNT_W-1:0]           count,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    list_fill,
    output int                                    results_checked,
    output int                                    range_hits,
    output int                                    full_hits
);
    import ile_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        status_t                  status;
        logic [COUNT_W-1:0]       count;
    } list_result_t;

    // Shadow copy of the list and its length.
    logic signed [DATA_W-1:0] entries [CAPACITY_DEF];
    int unsigned              fill;

    list_result_t expected_q [$];
    int           fails;
    int           seen;
    int           range_seen;
    int           full_seen;

    // Applies one request to the shadow list and returns the item it should produce.
    function automatic list_result_t apply_request(
        input logic [FUNC_W-1:0]        op,
        input logic signed [DATA_W-1:0] val,
        input logic [INDEX_W-1:0]       ia_in,
        input logic [INDEX_W-1:0]       ib_in
    );
        list_result_t             res;
        int unsigned              ia;
        int unsigned              ib;
        int unsigned              pos;
        logic signed [DATA_W-1:0] held;
        ia = ia_in;
        ib = ib_in;
        res.read_value = '0;
        res.status = STAT_DONE;
        case (op)
            FN_READ:
            begin
                if (ia >= fill)
                    res.status = STAT_RANGE;
                else
                    res.read_value = entries[ia];
            end
            FN_PUSH:
            begin
                if (fill >= CAPACITY_DEF)
                    res.status = STAT_FULL;
                else
                begin
                    entries[fill] = val;
                    fill++;
                end
            end
            FN_POP:
            begin
                if (fill == 0)
                    res.status = STAT_RANGE;
                else
                    fill--;
            end
            FN_INSERT:
            begin
                // The index is checked before the list is found full.
                if (ia > fill)
                    res.status = STAT_RANGE;
                else if (fill >= CAPACITY_DEF)
                    res.status = STAT_FULL;
                else
                begin
                    for (pos = fill; pos > ia; pos--)
                        entries[pos] = entries[pos - 1];
                    entries[ia] = val;
                    fill++;
                end
            end
            FN_REMOVE:
            begin
                if (ia >= fill)
                    res.status = STAT_RANGE;
                else
                begin
                    for (pos = ia; pos + 1 < fill; pos++)
                        entries[pos] = entries[pos + 1];
                    fill--;
                end
            end
            FN_SWAP:
            begin
                if (ia >= fill || ib >= fill)
                    res.status = STAT_RANGE;
                else
                begin
                    held = entries[ia];
                    entries[ia] = entries[ib];
                    entries[ib] = held;
                end
            end
            default:
            begin
                // Unused codes leave the list alone and report success.
            end
        endcase
        res.count = COUNT_W'(fill);
        return res;
    endfunction

    // Returned items are checked before the request of the same edge is predicted,
    // since a result can never belong to a request accepted at that very edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t want;
        list_result_t got;
        if (!rst_n)
        begin
            fill = 0;
            expected_q.delete();
            fails = 0;
            seen = 0;
            range_seen = 0;
            full_seen = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                got.read_value = read_value;
                got.status = status_t'(status);
                got.count = count;
                if (expected_q.size() == 0)
                begin
                    if (fails < MAX_REPORTS)
                        $display("Unexpected result item: read_value=%0d status=%0d count=%0d",
                                 got.read_value, got.status, got.count);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.read_value !== want.read_value || got.status !== want.status ||
                        got.count !== want.count)
                    begin
                        if (fails < MAX_REPORTS)
                            $display({"Result %0d differs: expected read_value=%0d status=%0d ",
                                      "count=%0d, got read_value=%0d status=%0d count=%0d"},
                                     seen, want.read_value, want.status, want.count,
                                     got.read_value, got.status, got.count);
                        fails++;
                    end
                    if (want.status == STAT_RANGE)
                        range_seen++;
                    if (want.status == STAT_FULL)
                        full_seen++;
                    seen++;
                end
            end
            if (req_valid && req_ready)
                expected_q.push_back(apply_request(func, value, index_a, index_b));
        end
        fail_count <= fails;
        pending <= expected_q.size();
        list_fill <= fill;
        results_checked <= seen;
        range_hits <= range_seen;
        full_hits <= full_seen;
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

// Drives requests into the list engine and gives the verdict; all prediction and
// comparison is done by the checker instantiated beside the block.
module testbench;
    import ile_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          TARGET_ITEMS = 650;
    localparam int          TAIL_CYCLES  = 40;
    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_t;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_ready;
    logic [FUNC_W-1:0]         func;
    logic signed [DATA_W-1:0]  value;
    logic [INDEX_W-1:0]        index_a;
    logic [INDEX_W-1:0]        index_b;
    logic                      rsp_valid;
    logic                      rsp_ready;
    logic signed [DATA_W-1:0]  read_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;

    int fail_count;
    int pending;
    int list_fill;
    int results_checked;
    int range_hits;
    int full_hits;

    int cycles = 0;
    int items_sent;
    int op_tally [8];
    bit steady;

    indexed_list_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .func       (func),
        .value      (value),
        .index_a    (index_a),
        .index_b    (index_b),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

    ile_list_checker list_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .func            (func),
        .value           (value),
        .index_a         (index_a),
        .index_b         (index_b),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .read_value      (read_value),
        .status          (status),
        .count           (count),
        .fail_count      (fail_count),
        .pending         (pending),
        .list_fill       (list_fill),
        .results_checked (results_checked),
        .range_hits      (range_hits),
        .full_hits       (full_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle gaps: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mostly a position inside the list, with its ends favoured and some anywhere.
    function automatic int unsigned pick_index(input int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (span == 0 || r < 12)
            return $urandom_range(0, CAPACITY_DEF);
        if (r < 22)
            return 0;
        if (r < 32)
            return span - 1;
        return $urandom_range(0, span - 1);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Growing phases favour push and insert, shrinking ones pop and remove.
    function automatic logic [FUNC_W-1:0] pick_op(input phase_t ph);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r >= 98)
            return r[0] ? FN_SPARE_A : FN_SPARE_B;
        case (ph)
            PH_GROW:
                return r < 35 ? FN_PUSH : r < 62 ? FN_INSERT : r < 75 ? FN_READ :
                       r < 85 ? FN_SWAP : r < 92 ? FN_POP : FN_REMOVE;
            PH_SHRINK:
                return r < 30 ? FN_POP : r < 60 ? FN_REMOVE : r < 75 ? FN_READ :
                       r < 85 ? FN_SWAP : r < 92 ? FN_PUSH : FN_INSERT;
            default:
                return FUNC_W'($urandom_range(0, 5));
        endcase
    endfunction

    // Presents one item, holds it until it is taken, then perhaps leaves a gap.
    task automatic issue(input logic [FUNC_W-1:0] op, input logic signed [DATA_W-1:0] val,
                         input int unsigned ia, input int unsigned ib);
        int unsigned gap;
        req_valid <= 1'b1;
        func <= op;
        value <= val;
        index_a <= INDEX_W'(ia);
        index_b <= INDEX_W'(ib);
        do @(posedge clk); while (!req_ready);
        op_tally[op]++;
        items_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds off the sender until every outstanding result has been returned.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Result side: runs of readiness broken by stalls, sometimes long ready stretches.
    initial
    begin : rsp_side
        int unsigned stall;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(40, 120)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            stall = pick_gap();
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results outstanding.", pending);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        phase_t            ph;
        int                phase_no;
        int unsigned       span;
        logic [FUNC_W-1:0] op;
        items_sent = 0;
        steady = 1'b0;
        foreach (op_tally[k])
            op_tally[k] = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        func = FN_READ;
        value = '0;
        index_a = '0;
        index_b = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every access is out of range, insert past the end is refused.
        issue(FN_POP, '0, 0, 0);
        issue(FN_READ, '0, 0, 0);
        issue(FN_REMOVE, '0, 0, 0);
        issue(FN_SWAP, '0, 0, 0);
        issue(FN_INSERT, 32'sd123, 1, 0);
        // Insert at the end of an empty list, then pop the single value.
        issue(FN_INSERT, VAL_MIN, 0, 0);
        issue(FN_POP, '0, 31, 31);
        issue(FN_INSERT, VAL_MIN, 0, 0);
        issue(FN_PUSH, VAL_MAX, 0, 0);
        // Fill to capacity with a mix of pushes and inserts in the middle.
        for (int n = 2; n < CAPACITY_DEF; n++)
        begin
            if (n % 2 == 0)
                issue(FN_PUSH, pick_value(), 0, 0);
            else
                issue(FN_INSERT, pick_value(), $urandom_range(1, n - 1), 0);
        end
        // Full list: push and insert at the end are refused, read past the end too.
        issue(FN_PUSH, '1, 0, 0);
        issue(FN_INSERT, '1, CAPACITY_DEF, 0);
        issue(FN_READ, '0, CAPACITY_DEF, 0);
        issue(FN_READ, '0, CAPACITY_DEF - 1, 0);
        issue(FN_SWAP, '0, 0, CAPACITY_DEF - 1);
        issue(FN_SWAP, '0, 5, 5);
        issue(FN_SWAP, '0, 3, CAPACITY_DEF);
        issue(FN_REMOVE, '0, 0, 0);
        issue(FN_REMOVE, '0, CAPACITY_DEF - 1, 0);
        issue(FN_SPARE_A, VAL_MAX, 31, 31);
        issue(FN_SPARE_B, VAL_MIN, 0, 0);
        wait_for_results();

        // Random phases in a grow, mix, shrink cycle with random content.
        phase_no = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            ph = phase_t'(phase_no % 3);
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(15, 50))
            begin
                op = pick_op(ph);
                span = (op == FN_INSERT) ? list_fill + 1 : list_fill;
                issue(op, pick_value(), pick_index(span), pick_index(list_fill));
            end
            steady = 1'b0;
            if ($urandom_range(0, 2) == 0)
                wait_for_results();
            phase_no++;
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display({"Sent %0d requests: %0d reads, %0d pushes, %0d pops, %0d inserts, ",
                  "%0d removes, %0d swaps, %0d unused codes."},
                 items_sent, op_tally[FN_READ], op_tally[FN_PUSH], op_tally[FN_POP],
                 op_tally[FN_INSERT], op_tally[FN_REMOVE], op_tally[FN_SWAP],
                 op_tally[FN_SPARE_A] + op_tally[FN_SPARE_B]);
        $display("Checked %0d results; %0d hit a bad index or empty list, %0d a full list.",
                 results_checked, range_hits, full_hits);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
